>>> rtl/core/llu_pkg.sv
`default_nettype none
package llu_pkg;

    // Angle and CORDIC datapath widths.
    localparam int ANG_W = 44;   // angle in units of 2^-32 degree
    localparam int Z_W   = 42;   // residual angle during rotation
    localparam int XY_W  = 44;   // CORDIC x and y in units of 2^-40
    localparam int Q_W   = 32;   // Q1.30 result width
    localparam int MAX_STEPS = 40;

    localparam logic signed [31:0] LAT_LIMIT = 32'sd5898240;
    localparam logic signed [31:0] LON_LIMIT = 32'sd23592960;
    localparam logic signed [XY_W-1:0] GAIN_Q40 = 44'sd667681663043;
    localparam logic [63:0] RAD2DEG_Q34 = 64'd984333996830;
    localparam logic signed [33:0] Q30_ONE = 34'sd1073741824;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_LAT_RANGE = 2'd1;
    localparam logic [1:0] STATUS_LON_RANGE = 2'd2;

    typedef struct packed {
        logic signed [31:0] latitude;
        logic signed [31:0] longitude;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic [1:0]         status;
    } out_item_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   neg_cos;
    } lane_t;

    typedef struct packed {
        logic [1:0] status;
        lane_t      lat;
        lane_t      lon;
    } cordic_t;

    // atan(2^-idx) in units of 2^-32 degree, built from the arctangent series
    // in Q62 radians and scaled to degrees; entry zero is exactly 45 degrees.
    function automatic logic [63:0] atan_entry(input int idx);
        logic signed [63:0] sum;
        logic [63:0]        term;
        logic [127:0]       prod;
        int                 e;
        sum = '0;
        if (idx == 0) begin
            return 64'd45 << 32;
        end
        for (int k = 0; k < 64; k++) begin
            e = 62 - idx * (2 * k + 1);
            if (e >= 0) begin
                term = (64'd1 << e) / 64'(2 * k + 1);
                if (k % 2 == 1) begin
                    sum = sum - $signed(term);
                end
                else begin
                    sum = sum + $signed(term);
                end
            end
        end
        prod = {64'd0, sum} * {64'd0, RAD2DEG_Q34};
        return prod[127:64];
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/latlon_to_unit_vector.sv
`default_nettype none
// Latitude/longitude to unit vector converter.
// An input item carries latitude and longitude in signed degrees scaled by
// 65536. The result item carries (cos lat cos lon, cos lat sin lon, sin lat)
// in signed Q1.30 and a status: ok, latitude out of [-90,90], or longitude
// out of [-360,360]. On an error all three components are zero.
// Both channels use valid and stall; an item moves on a clock edge where
// valid is high and stall is low.
// The accepted item passes through a chain of registers (step count capped
// at 40): range check and quadrant fold feed the first rotation register,
// then one register per rotation, a rounding register, a multiply register
// and the output register.
// One item is accepted every cycle while in_stall is low.
// The whole pipeline moves as one: when the output holds a valid item and
// the receiver stalls, every stage holds and in_stall goes high, so nothing
// is lost or repeated. Reset clears all valid bits, emptying the pipeline.
module latlon_to_unit_vector #(
    parameter int CORDIC_STEPS = 30
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_stall,
    input  wire llu_pkg::in_item_t in_data,
    output logic                   out_valid,
    input  wire                    out_stall,
    output llu_pkg::out_item_t     out_data
);
    import llu_pkg::*;

    localparam int NSTEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

    logic    advance;
    cordic_t prep;
    logic    stg_valid [NSTEPS+1];
    cordic_t stg_data  [NSTEPS+1];

    // The pipeline steps whenever the output register can take a new item.
    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    llu_prep u_prep (
        .item (in_data),
        .prep (prep)
    );

    assign stg_valid[0] = in_valid;
    assign stg_data[0]  = prep;

    // One registered stage per CORDIC rotation; both angles rotate side by side.
    for (genvar i = 0; i < NSTEPS; i++) begin : g_rot
        llu_cordic_stage #(
            .IDX (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (stg_valid[i]),
            .data_in   (stg_data[i]),
            .valid_out (stg_valid[i+1]),
            .data_out  (stg_data[i+1])
        );
    end

    // Rounds a 2^-40 value to Q1.30 (half up) and clamps to plus or minus one.
    function automatic logic signed [Q_W-1:0] to_q30(input logic signed [XY_W-1:0] v);
        logic signed [XY_W-1:0] s;
        logic signed [33:0]     r;
        s = (v + XY_W'(512)) >>> 10;
        r = s[33:0];
        if (r > Q30_ONE) begin
            r = Q30_ONE;
        end
        else if (r < -Q30_ONE) begin
            r = -Q30_ONE;
        end
        return r[Q_W-1:0];
    endfunction

    // Rounds a Q2.60 product back to Q1.30 and clamps it.
    function automatic logic signed [Q_W-1:0] prod_q30(input logic signed [63:0] p);
        logic signed [63:0] s;
        logic signed [33:0] r;
        s = (p + 64'sd536870912) >>> 30;
        r = s[33:0];
        if (r > Q30_ONE) begin
            r = Q30_ONE;
        end
        else if (r < -Q30_ONE) begin
            r = -Q30_ONE;
        end
        return r[Q_W-1:0];
    endfunction

    // Rounding stage: sine and cosine of both angles in Q1.30.
    logic                  rnd_valid_reg;
    logic [1:0]            rnd_status_reg;
    logic signed [Q_W-1:0] rnd_clat_reg, rnd_slat_reg, rnd_clon_reg, rnd_slon_reg;
    logic signed [Q_W-1:0] rnd_clat_next, rnd_clon_next;
    cordic_t               last;

    assign last = stg_data[NSTEPS];

    always_comb
    begin
        rnd_clat_next = to_q30(last.lat.x);
        rnd_clon_next = to_q30(last.lon.x);
        if (last.lat.neg_cos) begin
            rnd_clat_next = -rnd_clat_next;
        end
        if (last.lon.neg_cos) begin
            rnd_clon_next = -rnd_clon_next;
        end
    end

    // Multiply stage: products of cos(lat) with cos(lon) and sin(lon).
    logic                  mul_valid_reg;
    logic [1:0]            mul_status_reg;
    logic signed [63:0]    mul_x_reg, mul_y_reg;
    logic signed [Q_W-1:0] mul_z_reg;

    out_item_t out_next;

    always_comb
    begin
        out_next.status = mul_status_reg;
        if (mul_status_reg == STATUS_OK) begin
            out_next.vec_x = prod_q30(mul_x_reg);
            out_next.vec_y = prod_q30(mul_y_reg);
            out_next.vec_z = mul_z_reg;
        end
        else begin
            out_next.vec_x = '0;
            out_next.vec_y = '0;
            out_next.vec_z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rnd_valid_reg <= 1'b0;
            mul_valid_reg <= 1'b0;
            out_valid     <= 1'b0;
        end
        else if (advance) begin
            rnd_valid_reg <= stg_valid[NSTEPS];
            mul_valid_reg <= rnd_valid_reg;
            out_valid     <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            rnd_status_reg <= last.status;
            rnd_clat_reg   <= rnd_clat_next;
            rnd_slat_reg   <= to_q30(last.lat.y);
            rnd_clon_reg   <= rnd_clon_next;
            rnd_slon_reg   <= to_q30(last.lon.y);
            mul_status_reg <= rnd_status_reg;
            mul_x_reg      <= 64'(rnd_clat_reg) * 64'(rnd_clon_reg);
            mul_y_reg      <= 64'(rnd_clat_reg) * 64'(rnd_slon_reg);
            mul_z_reg      <= rnd_slat_reg;
            out_data       <= out_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/llu_prep.sv
`default_nettype none
module llu_prep (
    input  wire llu_pkg::in_item_t item,
    output llu_pkg::cordic_t       prep
);
    import llu_pkg::*;

    localparam logic signed [ANG_W-1:0] DEG90  = ANG_W'(90) <<< 32;
    localparam logic signed [ANG_W-1:0] DEG180 = ANG_W'(180) <<< 32;
    localparam logic signed [ANG_W-1:0] DEG360 = ANG_W'(360) <<< 32;

    // Wraps into (-180,180] and folds into [-90,90], noting a cosine sign flip.
    // Only angles that pass the range check matter, and those fit the angle width.
    function automatic lane_t reduce(input logic signed [31:0] deg);
        logic signed [ANG_W-1:0] a;
        lane_t                   l;
        a = {deg[ANG_W-17:0], 16'd0};
        l.x = GAIN_Q40;
        l.y = '0;
        l.neg_cos = 1'b0;
        if (a > DEG180) begin
            a = a - DEG360;
        end
        if (a <= -DEG180) begin
            a = a + DEG360;
        end
        if (a > DEG90) begin
            a = DEG180 - a;
            l.neg_cos = 1'b1;
        end
        else if (a < -DEG90) begin
            a = -DEG180 - a;
            l.neg_cos = 1'b1;
        end
        l.z = a[Z_W-1:0];
        return l;
    endfunction

    always_comb
    begin
        if (item.latitude < -LAT_LIMIT || item.latitude > LAT_LIMIT) begin
            prep.status = STATUS_LAT_RANGE;
        end
        else if (item.longitude < -LON_LIMIT || item.longitude > LON_LIMIT) begin
            prep.status = STATUS_LON_RANGE;
        end
        else begin
            prep.status = STATUS_OK;
        end
        prep.lat = reduce(item.latitude);
        prep.lon = reduce(item.longitude);
    end

endmodule
`default_nettype wire

>>> rtl/core/llu_cordic_stage.sv
`default_nettype none
module llu_cordic_stage #(
    parameter int IDX = 0
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   advance,
    input  wire                   valid_in,
    input  wire llu_pkg::cordic_t data_in,
    output logic                  valid_out,
    output llu_pkg::cordic_t      data_out
);
    import llu_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN = Z_W'(atan_entry(IDX));

    logic    valid_reg;
    cordic_t data_reg;
    cordic_t data_next;

    // One micro-rotation; positive residual angle rotates counterclockwise.
    function automatic lane_t rotate(input lane_t l);
        lane_t r;
        r = l;
        if (l.z >= 0) begin
            r.x = l.x - (l.y >>> IDX);
            r.y = l.y + (l.x >>> IDX);
            r.z = l.z - ATAN;
        end
        else begin
            r.x = l.x + (l.y >>> IDX);
            r.y = l.y - (l.x >>> IDX);
            r.z = l.z + ATAN;
        end
        return r;
    endfunction

    always_comb
    begin
        data_next.status = data_in.status;
        data_next.lat    = rotate(data_in.lat);
        data_next.lon    = rotate(data_in.lon);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (advance) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule
`default_nettype wire

>>> bench/latlon_to_unit_vector_test.sv
`default_nettype none
module latlon_to_unit_vector_test;
    import llu_pkg::*;

    // The converter keeps no state, so every item is checked on its own:
    // a software model of the range checks, the quadrant fold, the rotation
    // and the Q1.30 products predicts each result, and results are matched
    // in order against a queue of predictions.

    localparam int STEPS = 30;
    localparam int LATENCY = STEPS + 3;
    localparam int STALL_LIMIT = 4000;
    localparam longint DEG = 64'sd4294967296;
    localparam longint ONE_Q30 = 64'sd1073741824;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;

    latlon_to_unit_vector #(.CORDIC_STEPS(STEPS)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    always #1 clk = ~clk;

    // Arctangent table in units of 2^-32 degree, built independently from the
    // series for atan(2^-i) in Q62 radians, scaled by 180/pi in Q34.
    longint atan_tab [0:MAX_STEPS-1];

    function automatic longint series_atan(input int i);
        longint   sum;
        longint   term;
        logic [127:0] prod;
        int       k;
        int       e;
        sum = 0;
        k = 0;
        e = 62 - i;
        while (e >= 0)
        begin
            term = longint'((64'd1 << e) / 64'(2 * k + 1));
            sum = (k % 2 == 1) ? sum - term : sum + term;
            k++;
            e = 62 - i * (2 * k + 1);
        end
        prod = {64'd0, sum} * {64'd0, 64'd984333996830};
        return longint'(prod[127:64]);
    endfunction

    function automatic longint clamp_unit(input longint v);
        if (v > ONE_Q30) return ONE_Q30;
        if (v < -ONE_Q30) return -ONE_Q30;
        return v;
    endfunction

    // Sine and cosine of an angle in units of 2^-32 degree, in Q1.30.
    function automatic void rotate_angle(input longint ang, output longint sn,
                                         output longint cs);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     flip;
        x = 64'sd667681663043;
        y = 0;
        flip = 1'b0;
        if (ang > 180 * DEG) ang -= 360 * DEG;
        if (ang <= -180 * DEG) ang += 360 * DEG;
        if (ang > 90 * DEG)
        begin
            ang = 180 * DEG - ang;
            flip = 1'b1;
        end
        else if (ang < -90 * DEG)
        begin
            ang = -180 * DEG - ang;
            flip = 1'b1;
        end
        z = ang;
        for (int i = 0; i < STEPS && i < MAX_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= atan_tab[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += atan_tab[i];
            end
        end
        x = clamp_unit((x + 512) >>> 10);
        y = clamp_unit((y + 512) >>> 10);
        cs = flip ? -x : x;
        sn = y;
    endfunction

    function automatic longint product_q30(input longint a, input longint b);
        return clamp_unit((a * b + (64'sd1 << 29)) >>> 30);
    endfunction

    function automatic out_item_t predict_vector(input in_item_t it);
        out_item_t r;
        longint    lat;
        longint    lon;
        longint    slat, clat, slon, clon;
        r = '0;
        lat = it.latitude;
        lon = it.longitude;
        if (lat < -longint'(LAT_LIMIT) || lat > longint'(LAT_LIMIT))
            r.status = STATUS_LAT_RANGE;
        else if (lon < -longint'(LON_LIMIT) || lon > longint'(LON_LIMIT))
            r.status = STATUS_LON_RANGE;
        else
        begin
            rotate_angle(lat * 65536, slat, clat);
            rotate_angle(lon * 65536, slon, clon);
            r.vec_x = 32'(product_q30(clat, clon));
            r.vec_y = 32'(product_q30(clat, slon));
            r.vec_z = 32'(slat);
            r.status = STATUS_OK;
        end
        return r;
    endfunction

    // Directed rows: the expected result is typed in where it is obvious
    // (the range errors, which give a zero vector); the rest use the model.
    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } row_t;

    row_t rows [$];

    task automatic add_row(input int lat, input int lon, input bit typed,
                           input logic [1:0] st);
        row_t r;
        r.item.latitude = lat;
        r.item.longitude = lon;
        r.typed = typed;
        r.want = '0;
        r.want.status = st;
        rows.push_back(r);
    endtask

    out_item_t pending_vectors [$];
    int        fail_count = 0;
    int        idle_cycles = 0;
    int        send_idle_pct = 18;
    int        recv_idle_pct = 57;
    bit        stim_done = 1'b0;

    // Receiver: random stall, compare each accepted result with the oldest
    // prediction, field by field.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_vectors.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, out_data);
                fail_count++;
            end
            else
            begin
                out_item_t w;
                w = pending_vectors.pop_front();
                if (out_data.vec_x !== w.vec_x)
                begin
                    $display("%0t: vec_x expected %0d actual %0d", $time, w.vec_x, out_data.vec_x);
                    fail_count++;
                end
                if (out_data.vec_y !== w.vec_y)
                begin
                    $display("%0t: vec_y expected %0d actual %0d", $time, w.vec_y, out_data.vec_y);
                    fail_count++;
                end
                if (out_data.vec_z !== w.vec_z)
                begin
                    $display("%0t: vec_z expected %0d actual %0d", $time, w.vec_z, out_data.vec_z);
                    fail_count++;
                end
                if (out_data.status !== w.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, w.status, out_data.status);
                    fail_count++;
                end
            end
        end
        if (rst_n)
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Watchdog: counts cycles in which no item moves on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Sends one item, idling first at the current rate, and records the
    // prediction once the item is accepted.
    task automatic send_item(input in_item_t it, input out_item_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_vectors.push_back(want);
    endtask

    // Random angles: mostly valid ranges, with the range edges and wild
    // values mixed in so every input bit toggles.
    function automatic int pick_angle(input int limit);
        int c;
        c = $urandom_range(19);
        if (c == 0) return $urandom;
        if (c == 1) return limit + $signed($urandom_range(3)) - 1;
        if (c == 2) return -limit - $signed($urandom_range(3)) + 1;
        if (c == 3) return 90 * 65536 * $signed($urandom_range(8)) - 4 * 90 * 65536;
        return $signed($urandom_range(2 * limit)) - limit;
    endfunction

    initial
    begin
        in_item_t it;
        out_item_t w;
        for (int i = 0; i < MAX_STEPS; i++)
            atan_tab[i] = (i == 0) ? 45 * DEG : series_atan(i);

        add_row(0, 0, 1'b0, STATUS_OK);
        add_row(int'(LAT_LIMIT), 0, 1'b0, STATUS_OK);
        add_row(-int'(LAT_LIMIT), int'(LON_LIMIT), 1'b0, STATUS_OK);
        add_row(0, -int'(LON_LIMIT), 1'b0, STATUS_OK);
        add_row(0, 180 * 65536, 1'b0, STATUS_OK);
        add_row(0, -180 * 65536, 1'b0, STATUS_OK);
        add_row(0, 270 * 65536, 1'b0, STATUS_OK);
        add_row(45 * 65536, -90 * 65536, 1'b0, STATUS_OK);
        add_row(-30 * 65536, 181 * 65536 + 7, 1'b0, STATUS_OK);
        add_row(int'(LAT_LIMIT) + 1, 0, 1'b1, STATUS_LAT_RANGE);
        add_row(-int'(LAT_LIMIT) - 1, 0, 1'b1, STATUS_LAT_RANGE);
        add_row(32'h7fffffff, 32'h80000000, 1'b1, STATUS_LAT_RANGE);
        add_row(32'h80000000, 0, 1'b1, STATUS_LAT_RANGE);
        add_row(0, int'(LON_LIMIT) + 1, 1'b1, STATUS_LON_RANGE);
        add_row(0, -int'(LON_LIMIT) - 1, 1'b1, STATUS_LON_RANGE);
        add_row(-1, 32'h7fffffff, 1'b1, STATUS_LON_RANGE);
        add_row(1, 32'h80000000, 1'b1, STATUS_LON_RANGE);
        add_row(-1, -1, 1'b0, STATUS_OK);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            w = rows[i].typed ? rows[i].want : predict_vector(rows[i].item);
            send_item(rows[i].item, w);
        end

        // Three idling phases; the last one runs both sides flat out.
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 57 : 0;
            recv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 18 : 0;
            for (int n = 0; n < 630; n++)
            begin
                it.latitude = pick_angle(int'(LAT_LIMIT));
                it.longitude = pick_angle(int'(LON_LIMIT));
                send_item(it, predict_vector(it));
            end
        end
        in_valid <= 1'b0;

        while (pending_vectors.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire
